FILE: hdl/mpva_pkg.sv
// Shared types, codes and helpers for the MIDI parser / voice allocator.
// No dependencies; imported by every module of the block except mpva_ram.
package mpva_pkg;

   localparam int VOICES_DEFAULT = 8;
   localparam int SLOT_W         = 6;
   localparam int DATA_W         = 7;
   localparam int BEND_W         = 14;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int CHAN_W         = 4;

   // event / message kinds, as reported on event_type
   typedef enum logic [2:0] {
      K_NONE     = 3'd0,
      K_NOTE_ON  = 3'd1,
      K_NOTE_OFF = 3'd2,
      K_BEND     = 3'd3,
      K_CC       = 3'd4,
      K_PROG     = 3'd5
   } kind_type;

   // status byte upper nibbles
   localparam logic [3:0] ST_NOTE_OFF = 4'h8;
   localparam logic [3:0] ST_NOTE_ON  = 4'h9;
   localparam logic [3:0] ST_CC       = 4'hB;
   localparam logic [3:0] ST_PROG     = 4'hC;
   localparam logic [3:0] ST_BEND     = 4'hE;
   localparam logic [3:0] ST_SYSTEM   = 4'hF;

   // register indexes
   localparam logic [0:0] REG_LISTEN_CHANNEL = 1'b0;

   // completed-message view handed from the parser
   typedef struct packed {
      logic                done;
      kind_type            kind;
      logic [CHAN_W-1:0]   channel;
      logic [DATA_W-1:0]   first;
      logic [DATA_W-1:0]   second;
   } msg_type;

   // one voice table entry
   typedef struct packed {
      logic              on;
      logic [DATA_W-1:0] note;
      logic [DATA_W-1:0] velocity;
   } voice_entry_type;

   localparam int ENTRY_W = $bits(voice_entry_type);

   // voice engine result
   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } voice_res_type;

   function automatic kind_type decode_status(input logic [3:0] hi);
      kind_type k;
      k = K_NONE;
      unique case (hi)
         ST_NOTE_ON:  k = K_NOTE_ON;
         ST_NOTE_OFF: k = K_NOTE_OFF;
         ST_BEND:     k = K_BEND;
         ST_CC:       k = K_CC;
         ST_PROG:     k = K_PROG;
         default:     k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic two_data(input kind_type k);
      return (k == K_NOTE_ON) || (k == K_NOTE_OFF) || (k == K_BEND) || (k == K_CC);
   endfunction

endpackage

FILE: hdl/midi_parser_voice_allocator.sv
// MIDI byte parser with running status and a voice allocator over a RAM table.
// Depends on mpva_pkg, mpva_parser, mpva_voice_engine (and through it mpva_ram).
//
// One MIDI byte is taken per req transfer and exactly one result comes back per
// byte on the rsp channel. Channel messages (note on/off, pitch bend, control
// change, program change) are parsed with running status; system bytes are
// ignored. Messages completed on the channel in the listen_channel register
// (byte address 0) are reported; note on claims the lowest free voice, note
// off releases the lowest active voice holding that note. Timing: a byte that
// does not complete a note on/off on the listen channel is answered in the
// cycle after its transfer, so such bytes can stream at one per cycle while the
// output register is drained. A note on/off scans the voice table held in a
// single-port-read RAM, one entry per cycle, and its result is posted to the
// output register once the scan stops and the register is free. The next byte
// is accepted once the previous result has been posted to the output register
// and that register is empty or being drained. Voice table state starts
// cleared after reset without any clearing pass: per-entry valid flags mark
// entries that were never written as free.
module midi_parser_voice_allocator
   import mpva_pkg::*;
#(
   parameter int VOICES = VOICES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_midi_byte,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_event_fired,
   output logic [2:0]            rsp_event_type,
   output logic [DATA_W-1:0]     rsp_first_data,
   output logic [DATA_W-1:0]     rsp_second_data,
   output logic                  rsp_voice_hit,
   output logic [SLOT_W-1:0]     rsp_voice_slot,
   output logic [BEND_W-1:0]     rsp_bend_value,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic {
      T_IDLE  = 1'b0,
      T_VOICE = 1'b1
   } top_state_type;

   top_state_type      state_ff;
   logic [CHAN_W-1:0]  listen_ff;
   logic [BEND_W-1:0]  bend_ff, bend_in;

   // event held while the voice scan runs
   kind_type           pend_kind_ff;
   logic [DATA_W-1:0]  pend_first_ff;
   logic [DATA_W-1:0]  pend_second_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_fired_ff;
   kind_type           rsp_type_ff;
   logic [DATA_W-1:0]  rsp_first_ff;
   logic [DATA_W-1:0]  rsp_second_ff;
   logic               rsp_hit_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [BEND_W-1:0]  rsp_bend_ff;

   msg_type            msg;
   voice_res_type      vres;
   logic               accept;
   logic               slot_free;
   logic               fire;
   logic               voice_op;
   logic               start;
   logic               post_voice;
   logic               csr_wr;

   // output slot can take a new result this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == T_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   mpva_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .midi_byte (req_midi_byte),
      .msg       (msg)
   );

   assign fire     = msg.done && (msg.channel == listen_ff);
   assign voice_op = (msg.kind == K_NOTE_ON) || (msg.kind == K_NOTE_OFF);
   assign start    = accept && fire && voice_op;

   mpva_voice_engine #(
      .VOICES (VOICES)
   ) u_voice_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (msg.kind),
      .key      (msg.first),
      .velocity (msg.second),
      .ack      (slot_free),
      .result   (vres)
   );

   // scan result moves into the output register
   assign post_voice = (state_ff == T_VOICE) && vres.valid && slot_free;

   // drained unless refilled by a byte result or a scan result
   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (accept && !start) || post_voice;

   // pitch bend: msb in the second data byte
   assign bend_in = (fire && msg.kind == K_BEND) ? {msg.second, msg.first} : bend_ff;

   // register write at the access phase
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_LISTEN_CHANNEL)
                       ? CSR_DATA_W'(listen_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         listen_ff    <= '0;
         bend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr && csr_paddr[2] == REG_LISTEN_CHANNEL) begin
            listen_ff <= csr_pwdata[CHAN_W-1:0];
         end
         unique case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  bend_ff <= bend_in;
                  if (start) begin
                     state_ff <= T_VOICE;
                  end
               end
            end
            T_VOICE: begin
               if (post_voice) begin
                  state_ff <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase

         // payload registers
         if (start) begin
            pend_kind_ff   <= msg.kind;
            pend_first_ff  <= msg.first;
            pend_second_ff <= msg.second;
         end
         if (accept && !start) begin
            rsp_fired_ff  <= fire;
            rsp_type_ff   <= fire ? msg.kind : K_NONE;
            rsp_first_ff  <= fire ? msg.first : '0;
            rsp_second_ff <= fire ? msg.second : '0;
            rsp_hit_ff    <= 1'b0;
            rsp_slot_ff   <= '0;
            rsp_bend_ff   <= bend_in;
         end else if (post_voice) begin
            rsp_fired_ff  <= 1'b1;
            rsp_type_ff   <= pend_kind_ff;
            rsp_first_ff  <= pend_first_ff;
            rsp_second_ff <= pend_second_ff;
            rsp_hit_ff    <= vres.hit;
            rsp_slot_ff   <= vres.slot;
            rsp_bend_ff   <= bend_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_fired = rsp_fired_ff;
   assign rsp_event_type  = rsp_type_ff;
   assign rsp_first_data  = rsp_first_ff;
   assign rsp_second_data = rsp_second_ff;
   assign rsp_voice_hit   = rsp_hit_ff;
   assign rsp_voice_slot  = rsp_slot_ff;
   assign rsp_bend_value  = rsp_bend_ff;

endmodule

FILE: hdl/mpva_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mpva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/mpva_parser.sv
// MIDI channel-message parser with running status.
// Depends on mpva_pkg.
module mpva_parser
   import mpva_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  midi_byte,
   output msg_type     msg
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WAIT1 = 2'd1,
      PH_WAIT2 = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   phase_type            phase_ff, phase_in;
   kind_type             kind_ff, kind_in, status_kind;
   logic [CHAN_W-1:0]    chan_ff, chan_in;
   logic [DATA_W-1:0]    first_ff, first_in;
   logic [DATA_W-1:0]    second_ff, second_in;
   logic                 done;

   assign status_kind = decode_status(midi_byte[7:4]);

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      chan_in   = chan_ff;
      first_in  = first_ff;
      second_in = second_ff;
      done      = 1'b0;
      if (midi_byte[7]) begin
         // system bytes leave everything alone
         if (midi_byte[7:4] != ST_SYSTEM) begin
            kind_in = status_kind;
            if (status_kind != K_NONE) begin
               chan_in  = midi_byte[3:0];
               phase_in = PH_WAIT1;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      end else if (phase_ff == PH_WAIT1 || phase_ff == PH_DONE) begin
         first_in = midi_byte[DATA_W-1:0];
         if (two_data(kind_ff)) begin
            phase_in = PH_WAIT2;
         end else if (kind_ff == K_PROG) begin
            second_in = '0;
            phase_in  = PH_DONE;
            done      = 1'b1;
         end else begin
            phase_in = PH_IDLE;
         end
      end else if (phase_ff == PH_WAIT2) begin
         second_in = midi_byte[DATA_W-1:0];
         phase_in  = PH_DONE;
         done      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         kind_ff   <= K_NONE;
         chan_ff   <= '0;
         first_ff  <= '0;
         second_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         chan_ff   <= chan_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign msg.done    = done;
   assign msg.kind    = kind_ff;
   assign msg.channel = chan_ff;
   assign msg.first   = first_in;
   assign msg.second  = second_in;

endmodule

FILE: hdl/mpva_voice_engine.sv
// Voice table search and update: scans a RAM-held table one entry per cycle.
// Depends on mpva_pkg and mpva_ram.
module mpva_voice_engine
   import mpva_pkg::*;
#(
   parameter int VOICES = VOICES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  kind_type          op,
   input  logic [DATA_W-1:0] key,
   input  logic [DATA_W-1:0] velocity,
   input  logic              ack,
   output voice_res_type     result
);

   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

   typedef enum logic [1:0] {
      E_IDLE = 2'd0,
      E_SCAN = 2'd1,
      E_DONE = 2'd2
   } eng_state_type;

   eng_state_type     state_ff;
   logic [IDX_W-1:0]  chk_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  slot_ff;
   kind_type          op_ff;
   logic [DATA_W-1:0] key_ff;
   logic [DATA_W-1:0] vel_ff;
   logic [VOICES-1:0] valid_ff;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   voice_entry_type   entry;
   logic              entry_on;
   logic              match;
   logic              last;
   logic              wr_en;
   voice_entry_type   wr_entry;

   // entries never written read as off
   assign entry    = voice_entry_type'(rd_raw);
   assign entry_on = valid_ff[chk_ff] & entry.on;
   assign match    = (op_ff == K_NOTE_ON) ? !entry_on : (entry_on && entry.note == key_ff);
   assign last     = (chk_ff == IDX_W'(VOICES - 1));

   assign rd_en   = start || (state_ff == E_SCAN);
   assign rd_addr = start ? '0 : IDX_W'(chk_ff + 1'b1);

   assign wr_en             = (state_ff == E_SCAN) && match;
   assign wr_entry.on       = (op_ff == K_NOTE_ON);
   assign wr_entry.note     = (op_ff == K_NOTE_ON) ? key_ff : entry.note;
   assign wr_entry.velocity = vel_ff;

   mpva_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (VOICES)
   ) u_voice_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (chk_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         valid_ff <= '0;
         chk_ff   <= '0;
         hit_ff   <= 1'b0;
         slot_ff  <= '0;
      end else begin
         unique case (state_ff)
            E_IDLE: begin
               if (start) begin
                  state_ff <= E_SCAN;
                  chk_ff   <= '0;
               end
            end
            E_SCAN: begin
               if (match) begin
                  valid_ff[chk_ff] <= 1'b1;
                  hit_ff           <= 1'b1;
                  slot_ff          <= chk_ff;
                  state_ff         <= E_DONE;
               end else if (last) begin
                  hit_ff   <= 1'b0;
                  slot_ff  <= '0;
                  state_ff <= E_DONE;
               end else begin
                  chk_ff <= IDX_W'(chk_ff + 1'b1);
               end
            end
            E_DONE: begin
               if (ack) begin
                  state_ff <= E_IDLE;
               end
            end
            default: state_ff <= E_IDLE;
         endcase
      end
   end

   // operands held for the scan
   always_ff @(posedge clock) begin
      if (start) begin
         op_ff  <= op;
         key_ff <= key;
         vel_ff <= velocity;
      end
   end

   assign result.valid = (state_ff == E_DONE);
   assign result.hit   = hit_ff;
   assign result.slot  = SLOT_W'(slot_ff);

endmodule

FILE: tb/midi_parser_voice_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for midi_parser_voice_allocator: MIDI byte stream in, one result per
// byte out, compared against an in-bench parser and voice table predictor.
// Depends on mpva_pkg and the midi_parser_voice_allocator RTL only.
module midi_parser_voice_allocator_tb;
   import mpva_pkg::*;

   localparam int NUM_VOICES    = VOICES_DEFAULT;
   localparam int CYCLE_LIMIT   = 400_000;
   // worst case note on/off scan plus output register
   localparam int SETTLE_CYCLES = NUM_VOICES + 6;
   localparam logic [CSR_ADDR_W-1:0] LISTEN_ADDR = CSR_ADDR_W'(4 * REG_LISTEN_CHANNEL);

   // channel statuses the block parses but discards
   localparam logic [3:0] ST_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] ST_CHAN_PRESSURE = 4'hD;

   typedef enum logic [1:0] {
      PARSE_IDLE,
      PARSE_WAIT1,
      PARSE_WAIT2,
      PARSE_DONE
   } parse_state_type;

   typedef struct packed {
      logic              fired;
      kind_type          etype;
      logic [DATA_W-1:0] first;
      logic [DATA_W-1:0] second;
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [BEND_W-1:0] bend;
   } midi_result_type;

   // ---------------------------------------------------------------------------------------------
   // DUT signals
   // ---------------------------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_midi_byte;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_event_fired;
   logic [2:0]            rsp_event_type;
   logic [DATA_W-1:0]     rsp_first_data;
   logic [DATA_W-1:0]     rsp_second_data;
   logic                  rsp_voice_hit;
   logic [SLOT_W-1:0]     rsp_voice_slot;
   logic [BEND_W-1:0]     rsp_bend_value;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   midi_parser_voice_allocator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_midi_byte   (req_midi_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_fired (rsp_event_fired),
      .rsp_event_type  (rsp_event_type),
      .rsp_first_data  (rsp_first_data),
      .rsp_second_data (rsp_second_data),
      .rsp_voice_hit   (rsp_voice_hit),
      .rsp_voice_slot  (rsp_voice_slot),
      .rsp_bend_value  (rsp_bend_value),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------------
   // Predictor state: parser, voice table, shared bend and the listen channel register
   // ---------------------------------------------------------------------------------------------
   parse_state_type   parse_state;
   kind_type          cur_kind;
   logic [3:0]        cur_channel;
   logic [DATA_W-1:0] held_first;
   logic [DATA_W-1:0] held_second;
   logic              voice_on   [NUM_VOICES];
   logic [DATA_W-1:0] voice_note [NUM_VOICES];
   logic [BEND_W-1:0] shared_bend;
   logic [3:0]        listen_ch;

   midi_result_type pending_results [$];   // expected results, oldest first
   int              mismatch_count = 0;
   int              bytes_sent     = 0;
   int              cycle_count    = 0;

   // idling controls; both off for the closing stretch
   bit req_gaps_on = 1'b1;
   bit rsp_gaps_on = 1'b1;
   int rsp_hold_cycles = 0;   // long receiver stall requested by a test
   int rsp_stall_left  = 0;

   function automatic logic [7:0] status_of(input logic [3:0] nibble, input logic [3:0] ch);
      return {nibble, ch};
   endfunction

   // Advance the parser by one byte and return what the block must report for it.
   function automatic midi_result_type parse_midi_byte(input logic [7:0] b);
      midi_result_type r;
      logic            done;
      kind_type        k;
      r    = '0;
      done = 1'b0;
      if (b[7]) begin
         // system bytes leave everything alone
         if (b[7:4] != ST_SYSTEM) begin
            unique case (b[7:4])
               ST_NOTE_ON:  k = K_NOTE_ON;
               ST_NOTE_OFF: k = K_NOTE_OFF;
               ST_BEND:     k = K_BEND;
               ST_CC:       k = K_CC;
               ST_PROG:     k = K_PROG;
               default:     k = K_NONE;
            endcase
            cur_kind = k;
            if (k != K_NONE) begin
               cur_channel = b[3:0];
               parse_state = PARSE_WAIT1;
            end else begin
               parse_state = PARSE_IDLE;
            end
         end
      end else if (parse_state == PARSE_WAIT1 || parse_state == PARSE_DONE) begin
         // PARSE_DONE here is running status
         held_first = b[DATA_W-1:0];
         if (cur_kind == K_PROG) begin
            held_second = '0;
            parse_state = PARSE_DONE;
            done        = 1'b1;
         end else if (cur_kind != K_NONE) begin
            parse_state = PARSE_WAIT2;
         end else begin
            parse_state = PARSE_IDLE;
         end
      end else if (parse_state == PARSE_WAIT2) begin
         held_second = b[DATA_W-1:0];
         parse_state = PARSE_DONE;
         done        = 1'b1;
      end

      if (done && cur_channel == listen_ch) begin
         r.fired  = 1'b1;
         r.etype  = cur_kind;
         r.first  = held_first;
         r.second = (cur_kind == K_PROG) ? '0 : held_second;
         case (cur_kind)
            K_NOTE_ON: begin
               for (int i = 0; i < NUM_VOICES; i++) begin
                  if (!r.hit && !voice_on[i]) begin
                     voice_on[i]   = 1'b1;
                     voice_note[i] = held_first;
                     r.hit         = 1'b1;
                     r.slot        = SLOT_W'(i);
                  end
               end
            end
            K_NOTE_OFF: begin
               for (int i = 0; i < NUM_VOICES; i++) begin
                  if (!r.hit && voice_on[i] && voice_note[i] == held_first) begin
                     voice_on[i] = 1'b0;
                     r.hit       = 1'b1;
                     r.slot      = SLOT_W'(i);
                  end
               end
            end
            K_BEND: shared_bend = {held_second, held_first};
            default: ;
         endcase
      end
      r.bend = shared_bend;
      return r;
   endfunction

   function automatic string fmt_result(input midi_result_type r);
      return $sformatf("fired=%0d type=%0d first=%0d second=%0d hit=%0d slot=%0d bend=%0d",
                       r.fired, r.etype, r.first, r.second, r.hit, r.slot, r.bend);
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Byte sender: optional idle burst, then hold valid until the transfer happens.
   // Every call starts and ends right after a rising edge.
   // ---------------------------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_midi_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // transfer at this edge; the result can come no earlier than the next one
      pending_results.push_back(parse_midi_byte(b));
      bytes_sent++;
   endtask

   task automatic send_sequence(input logic [7:0] seq [$]);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // Stop offering bytes and let every expected result come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; the register takes it at the pready edge.
   task automatic write_listen_channel(input logic [3:0] ch);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LISTEN_ADDR;
      csr_pwdata  <= CSR_DATA_W'(ch);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      listen_ch = ch;
   endtask

   // data byte; note-like bytes come from a narrow pool so note offs find their voices
   function automatic logic [7:0] rand_data(input bit note_like);
      if (note_like && $urandom_range(0, 9) < 7)
         return {1'b0, 7'(60 + $urandom_range(0, 7))};
      return {1'b0, 7'($urandom)};
   endfunction

   // One message, mostly well formed: running status, stray system bytes, truncation and noise
   // mixed in at low rates.
   task automatic send_random_message();
      int         pick;
      int         ndata;
      logic [3:0] ch;
      logic [3:0] nibble;
      bit         note_like;
      ch   = ($urandom_range(0, 3) != 0) ? listen_ch : 4'($urandom);
      pick = $urandom_range(0, 99);
      note_like = 1'b0;
      ndata     = 2;
      if (pick < 30) begin
         nibble    = ST_NOTE_ON;
         note_like = 1'b1;
      end else if (pick < 55) begin
         nibble    = ST_NOTE_OFF;
         note_like = 1'b1;
      end else if (pick < 65) begin
         nibble = ST_BEND;
      end else if (pick < 75) begin
         nibble = ST_CC;
      end else if (pick < 85) begin
         nibble = ST_PROG;
         ndata  = $urandom_range(1, 3);
      end else if (pick < 91) begin
         nibble = ($urandom_range(0, 1) != 0) ? ST_POLY_PRESSURE : ST_CHAN_PRESSURE;
         ndata  = $urandom_range(0, 2);
      end else if (pick < 95) begin
         nibble = ST_SYSTEM;
         ndata  = 0;
      end else begin
         // raw noise byte, any value
         send_byte(8'($urandom));
         return;
      end

      // about a third of the messages lean on running status
      if (nibble == ST_SYSTEM || nibble == ST_POLY_PRESSURE || nibble == ST_CHAN_PRESSURE ||
          $urandom_range(0, 2) != 0)
         send_byte(status_of(nibble, ch));
      for (int i = 0; i < ndata; i++) begin
         if ($urandom_range(0, 19) == 0) send_byte(status_of(ST_SYSTEM, 4'($urandom)));
         if (i > 0 && $urandom_range(0, 19) == 0) break;   // cut short
         send_byte(rand_data(note_like && i == 0));
      end
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) send_random_message();
   endtask

   // ---------------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------------

   // Field extremes, every message kind and the corner cases of the parser.
   task automatic test_directed();
      send_sequence('{
         8'h40,                                           // data while idle
         status_of(ST_NOTE_ON, 4'h0), 8'h00, 8'h00,       // lowest note, velocity zero
         8'h7F, 8'h7F,                                    // running status, highest note
         status_of(ST_NOTE_OFF, 4'h0), 8'h7F,
         status_of(ST_SYSTEM, 4'h8), 8'h40,               // system byte inside a message
         status_of(ST_BEND, 4'h0), 8'h7F, 8'h7F,          // full scale bend
         status_of(ST_CC, 4'h0), 8'h00, 8'h7F,
         status_of(ST_PROG, 4'h0), 8'h05, 8'h7F,          // program change running status
         status_of(ST_POLY_PRESSURE, 4'h0), 8'h10, 8'h20, // parser goes idle
         status_of(ST_CHAN_PRESSURE, 4'h0), 8'h11,
         status_of(ST_NOTE_ON, 4'h3), 8'h10, 8'h10,       // other channel
         status_of(ST_SYSTEM, 4'hF)
      });
   endtask

   // Fill every voice, overflow, release in odd order, duplicate notes take the lowest slot.
   task automatic test_voice_table();
      wait_until_drained();
      write_listen_channel(4'd9);
      send_byte(status_of(ST_NOTE_ON, 4'd9));
      for (int i = 0; i <= NUM_VOICES; i++) begin
         send_byte(8'(8'h10 + i));
         send_byte(8'(8'h01 + 13 * i));
      end
      send_byte(status_of(ST_NOTE_OFF, 4'd9));
      send_sequence('{8'(8'h10 + NUM_VOICES), 8'h00,    // never got a voice
                      8'h13, 8'h7F, 8'h10, 8'h20});
      send_sequence('{status_of(ST_NOTE_ON, 4'd9), 8'h15, 8'h30,
                      status_of(ST_NOTE_OFF, 4'd9), 8'h15, 8'h00, 8'h15, 8'h00, 8'h15, 8'h00,
                      status_of(ST_BEND, 4'd9), 8'h00, 8'h00});
   endtask

   // Receiver stalls for a long stretch while bytes keep coming; the input must back up.
   task automatic test_backpressure();
      req_gaps_on     = 1'b0;
      rsp_hold_cycles = 80;
      test_random_traffic(60);
      req_gaps_on = 1'b1;
   endtask

   // Sender goes quiet until everything has come back, then resumes.
   task automatic test_drain_pause();
      test_random_traffic(30);
      wait_until_drained();
      test_random_traffic(30);
   endtask

   task automatic test_listen_channel(input logic [3:0] ch, input int n_bytes);
      wait_until_drained();
      write_listen_channel(ch);
      test_random_traffic(n_bytes);
   endtask

   // Closing stretch with neither side idling.
   task automatic test_steady_stream();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      test_random_traffic(150);
   endtask

   // ---------------------------------------------------------------------------------------------
   // Receiver: random ready bursts, plus long holds on request
   // ---------------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_cycles != 0) begin
         rsp_stall_left  = rsp_hold_cycles;
         rsp_hold_cycles = 0;
      end else if (rsp_stall_left == 0 && rsp_gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(1, 9);
      end
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker: each transfer against the oldest expectation.
   always @(posedge clock) begin
      midi_result_type seen;
      midi_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{fired: rsp_event_fired, etype: kind_type'(rsp_event_type),
                  first: rsp_first_data, second: rsp_second_data, hit: rsp_voice_hit,
                  slot: rsp_voice_slot, bend: rsp_bend_value};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transfer: %s", fmt_result(seen));
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch\n  expected %s\n  actual   %s",
                           fmt_result(want), fmt_result(seen));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_midi_byte = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;

      // predictor reset state
      parse_state = PARSE_IDLE;
      cur_kind    = K_NONE;
      cur_channel = '0;
      held_first  = '0;
      held_second = '0;
      shared_bend = '0;
      listen_ch   = '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
         voice_on[i]   = 1'b0;
         voice_note[i] = '0;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_listen_channel(4'd0);
      test_directed();
      test_voice_table();
      test_backpressure();
      test_drain_pause();
      test_listen_channel(4'd15, 280);
      test_listen_channel(4'd0, 280);
      test_listen_channel(4'($urandom), 280);
      test_listen_channel(4'($urandom), 280);
      test_steady_stream();

      wait_until_drained();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
